// ----- rtl/fca_pkg.sv -----
`timescale 1ns / 1ps
// fca_pkg: shared types and constants for the chain allocator.
// Depends on nothing; imported by fat_chain_allocator_unit.

package fca_pkg;

	localparam int unsigned CNT_W  = 13;
	localparam int unsigned LINK_W = 16;
	localparam int unsigned BSL_W  = 5;
	localparam int unsigned LEN_W  = 32;

	localparam logic [LINK_W-1:0] FREE_MARK = 16'hFFFF;
	localparam logic [LINK_W-1:0] END_MARK  = 16'h0FFF;

	localparam logic [BSL_W-1:0] BSL_RESET = 5'd10;

	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_COUNT = 2'd2;
	localparam logic [1:0] REQ_NEXT  = 2'd3;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_NOSPACE  = 2'd1;
	localparam logic [1:0] STS_BADBLOCK = 2'd2;
	localparam logic [1:0] STS_LOOP     = 2'd3;

	// Result word, status in the lowest bits.
	typedef struct packed {
		logic [CNT_W-1:0]  free_total;
		logic [LINK_W-1:0] next_link;
		logic [CNT_W-1:0]  block_total;
		logic [LINK_W-1:0] head_block;
		logic [1:0]        status;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);
	localparam int unsigned OUT_W = 64;
	localparam int unsigned IN_W  = 56;

endpackage

// ----- rtl/fat_chain_allocator_unit.sv -----
`timescale 1ns / 1ps
// fat_chain_allocator_unit: link table of block chains with a free-block count; uses fca_pkg.
// Flow: S_IDLE takes a word, S_DISPATCH decodes it; allocate scans from index 0 (S_A_SCAN,
// S_A_END), free and count walk the chain (S_W_EVAL), next-link reads in S_N_READ, and S_DONE
// waits while the previous reply sits in the output register. One word is in work at a time;
// s_tready returns with the reply. The one table read port and one-link-per-cycle walk
// set the rate. Reset: asynchronous, active low; a clearing pass then frees every entry.

module fat_chain_allocator_unit
	import fca_pkg::*;
#(
	parameter int unsigned TABLE_ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [BSL_W-1:0]     cfg_wdata,    // block_size_log2
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// s_tdata: req_type[1:0], length_bytes[33:2], start_block[49:34], zeros above
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// m_tdata: status[1:0], head_block[17:2], block_total[30:18], next_link[46:31],
	// free_total[59:47], zeros above
	output logic [OUT_W-1:0]     m_tdata
);

	localparam int unsigned IW = $clog2(TABLE_ENTRIES);

	localparam logic [LINK_W-1:0] TE_L    = LINK_W'(TABLE_ENTRIES);
	localparam logic [IW:0]       TE_S    = (IW+1)'(TABLE_ENTRIES);
	localparam logic [CNT_W-1:0]  TE_C    = CNT_W'(TABLE_ENTRIES);
	localparam logic [IW-1:0]     TE_LAST = IW'(TABLE_ENTRIES - 1);
	// Index 0xFFF is never handed out, so it is not counted when it lies inside the table.
	localparam logic [CNT_W-1:0]  FREE_RESET =
		(TABLE_ENTRIES > 4095) ? CNT_W'(TABLE_ENTRIES - 1) : CNT_W'(TABLE_ENTRIES);

	// Sequencer states.
	localparam logic [2:0] S_CLEAR    = 3'd0;
	localparam logic [2:0] S_IDLE     = 3'd1;
	localparam logic [2:0] S_DISPATCH = 3'd2;
	localparam logic [2:0] S_A_SCAN   = 3'd3;
	localparam logic [2:0] S_A_END    = 3'd4;
	localparam logic [2:0] S_W_EVAL   = 3'd5;
	localparam logic [2:0] S_N_READ   = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	// The link table: one write port and one registered read port, write-first.
	logic [LINK_W-1:0] link_mem [TABLE_ENTRIES];
	logic              mem_we;
	logic [IW-1:0]     mem_waddr;
	logic [LINK_W-1:0] mem_wdata;
	logic [IW-1:0]     mem_raddr;
	logic [LINK_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_we && (mem_waddr == mem_raddr)) begin
			rdata_q <= mem_wdata;
		end else begin
			rdata_q <= link_mem[mem_raddr];
		end
	end

	// Configuration register.
	logic [BSL_W-1:0] bsl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bsl_q <= BSL_RESET;
		end else if (cfg_we) begin
			bsl_q <= cfg_wdata;
		end
	end

	// Sequencer registers.
	logic [2:0]        state_q, state_d;
	logic [IW-1:0]     clr_q, clr_d;
	logic [CNT_W-1:0]  free_q, free_d;
	logic [1:0]        req_q, req_d;
	logic [LEN_W-1:0]  len_q, len_d;
	logic [LINK_W-1:0] start_q, start_d;
	logic [CNT_W-1:0]  need_q, need_d;
	logic [IW:0]       scan_q, scan_d;
	logic              ev_vld_q, ev_vld_d;
	logic [IW-1:0]     ev_idx_q, ev_idx_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              prev_vld_q, prev_vld_d;
	logic [IW-1:0]     prev_q, prev_d;
	logic [IW-1:0]     cur_q, cur_d;
	res_t              res_q, res_d;
	logic              out_vld_q, out_vld_d;
	res_t              out_q, out_d;

	// Allocation sizing: blocks needed is the length rounded up to whole blocks, at least one.
	logic [LEN_W-1:0] len_shift;
	logic [LEN_W-1:0] len_lowmask;
	logic [LEN_W:0]   need_full;
	logic [CNT_W-1:0] cnt_inc;
	logic             scan_hit;

	assign len_shift   = len_q >> bsl_q;
	assign len_lowmask = ~({LEN_W{1'b1}} << bsl_q);
	assign cnt_inc     = cnt_q + CNT_W'(1);
	assign scan_hit    = ev_vld_q && (rdata_q == FREE_MARK) &&
		(LINK_W'(ev_idx_q) != END_MARK);

	always_comb begin
		need_full = {1'b0, len_shift} + (LEN_W+1)'(|(len_q & len_lowmask));
		if (need_full == '0) begin
			need_full = (LEN_W+1)'(1);
		end
	end

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d    = state_q;
		clr_d      = clr_q;
		free_d     = free_q;
		req_d      = req_q;
		len_d      = len_q;
		start_d    = start_q;
		need_d     = need_q;
		scan_d     = scan_q;
		ev_vld_d   = ev_vld_q;
		ev_idx_d   = ev_idx_q;
		cnt_d      = cnt_q;
		prev_vld_d = prev_vld_q;
		prev_d     = prev_q;
		cur_d      = cur_q;
		res_d      = res_q;
		out_d      = out_q;
		out_vld_d  = out_vld_q && !m_tready;
		mem_we     = 1'b0;
		mem_waddr  = clr_q;
		mem_wdata  = FREE_MARK;
		mem_raddr  = cur_q;

		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == TE_LAST) begin
					state_d = S_IDLE;
				end else begin
					clr_d = clr_q + IW'(1);
				end
			end
			S_IDLE: begin
				if (s_tvalid) begin
					req_d   = s_tdata[1:0];
					len_d   = s_tdata[33:2];
					start_d = s_tdata[49:34];
					res_d.status      = STS_OK;
					res_d.head_block  = FREE_MARK;
					res_d.block_total = '0;
					res_d.next_link   = FREE_MARK;
					res_d.free_total  = '0;
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cnt_d = '0;
				unique case (req_q)
					REQ_ALLOC: begin
						if (need_full > (LEN_W+1)'(free_q)) begin
							res_d.status = STS_NOSPACE;
							state_d      = S_DONE;
						end else begin
							need_d     = need_full[CNT_W-1:0];
							scan_d     = '0;
							ev_vld_d   = 1'b0;
							prev_vld_d = 1'b0;
							state_d    = S_A_SCAN;
						end
					end
					REQ_FREE, REQ_COUNT: begin
						if (start_q == FREE_MARK || start_q == END_MARK) begin
							state_d = S_DONE;
						end else if (start_q >= TE_L) begin
							res_d.status = STS_BADBLOCK;
							state_d      = S_DONE;
						end else begin
							mem_raddr = start_q[IW-1:0];
							cur_d     = start_q[IW-1:0];
							state_d   = S_W_EVAL;
						end
					end
					REQ_NEXT: begin
						if (start_q == FREE_MARK) begin
							state_d = S_DONE;
						end else if (start_q >= TE_L) begin
							res_d.status = STS_BADBLOCK;
							state_d      = S_DONE;
						end else begin
							mem_raddr = start_q[IW-1:0];
							state_d   = S_N_READ;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_A_SCAN: begin
				// Reads run one index ahead of the free-entry test on the returned data.
				mem_raddr = scan_q[IW-1:0];
				ev_vld_d  = (scan_q < TE_S);
				ev_idx_d  = scan_q[IW-1:0];
				if (scan_q < TE_S) begin
					scan_d = scan_q + (IW+1)'(1);
				end
				if (scan_hit) begin
					if (prev_vld_q) begin
						mem_we    = 1'b1;
						mem_waddr = prev_q;
						mem_wdata = LINK_W'(ev_idx_q);
					end else begin
						res_d.head_block = LINK_W'(ev_idx_q);
					end
					prev_d     = ev_idx_q;
					prev_vld_d = 1'b1;
					cnt_d      = cnt_inc;
					if (cnt_inc == need_q) begin
						state_d = S_A_END;
					end
				end else if (!ev_vld_q && scan_q >= TE_S) begin
					state_d = S_A_END;
				end
			end
			S_A_END: begin
				if (prev_vld_q) begin
					mem_we    = 1'b1;
					mem_waddr = prev_q;
					mem_wdata = END_MARK;
				end
				free_d            = free_q - cnt_q;
				res_d.block_total = cnt_q;
				state_d           = S_DONE;
			end
			S_W_EVAL: begin
				// rdata_q holds the link of cur_q; the next read is issued from it directly.
				if (rdata_q == FREE_MARK) begin
					res_d.status      = STS_BADBLOCK;
					res_d.block_total = cnt_q;
					state_d           = S_DONE;
				end else if (cnt_q >= TE_C) begin
					res_d.status      = STS_LOOP;
					res_d.block_total = cnt_q;
					state_d           = S_DONE;
				end else begin
					if (req_q == REQ_FREE) begin
						mem_we    = 1'b1;
						mem_waddr = cur_q;
						mem_wdata = FREE_MARK;
						free_d    = free_q + CNT_W'(1);
					end
					cnt_d = cnt_inc;
					if (rdata_q == END_MARK) begin
						res_d.block_total = cnt_inc;
						state_d           = S_DONE;
					end else if (rdata_q >= TE_L) begin
						res_d.status      = STS_BADBLOCK;
						res_d.block_total = cnt_inc;
						state_d           = S_DONE;
					end else begin
						mem_raddr = rdata_q[IW-1:0];
						cur_d     = rdata_q[IW-1:0];
					end
				end
			end
			S_N_READ: begin
				res_d.next_link = rdata_q;
				state_d         = S_DONE;
			end
			S_DONE: begin
				if (!out_vld_q || m_tready) begin
					out_d            = res_q;
					out_d.free_total = free_q;
					out_vld_d        = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			free_q     <= FREE_RESET;
			ev_vld_q   <= 1'b0;
			prev_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_q      <= clr_d;
			free_q     <= free_d;
			ev_vld_q   <= ev_vld_d;
			prev_vld_q <= prev_vld_d;
			out_vld_q  <= out_vld_d;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		req_q    <= req_d;
		len_q    <= len_d;
		start_q  <= start_d;
		need_q   <= need_d;
		scan_q   <= scan_d;
		ev_idx_q <= ev_idx_d;
		cnt_q    <= cnt_d;
		prev_q   <= prev_d;
		cur_q    <= cur_d;
		res_q    <= res_d;
		out_q    <= out_d;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {{(OUT_W-RES_W){1'b0}}, out_q};

`ifndef SYNTHESIS
	// The free count can never exceed the number of allocatable entries.
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= FREE_RESET)
		else $error("free count above table capacity");

	// The scan always stops as soon as the last needed block has been taken.
	a_scan_short: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_A_SCAN) |-> (cnt_q < need_q))
		else $error("allocation scan overran its block count");

	// The table is never written while the block waits for a request.
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("table written while idle");

	// A refused allocation leaves no chain behind.
	a_nospace_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_q.status == STS_NOSPACE) |->
		(out_q.head_block == FREE_MARK && out_q.block_total == '0))
		else $error("no-space result carries a chain");
`endif

endmodule
